>>> src/assert_macros.svh
// Assertion macros for the RTL of the packet assembler, included by the top level.
// The including module must provide signals named clk and rst_n.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define KWPA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define KWPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KWPA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define KWPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/kwpa_pkg.sv
// Package of the keyed word packet assembler: sizes, register indexes,
// result codes and the structs passed between the front, queue and back.
// No dependencies.
package kwpa_pkg;

    localparam int PACKET_WORDS = 68;
    localparam int WORD_W       = 32;
    localparam int FILL_W       = $clog2(PACKET_WORDS + 1);
    localparam int ROWS         = (PACKET_WORDS + 1) / 2;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NUM_BUFS     = 2;
    localparam int BUF_W        = 1;
    localparam int MEM_AW       = BUF_W + ROW_W;
    localparam int MEM_DEPTH    = 1 << MEM_AW;
    localparam int QCNT_W       = BUF_W + 1;

    localparam logic [WORD_W-1:0] END_FLAG = {1'b1, {(WORD_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_SEQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 2'd2;

    // Word counts carried by one result.
    localparam int NW_W = 2;
    localparam logic [NW_W-1:0] NW_NONE = 2'd0;
    localparam logic [NW_W-1:0] NW_ONE  = 2'd1;
    localparam logic [NW_W-1:0] NW_TWO  = 2'd2;

    // Flush command: which buffer, how many words, and the header word.
    typedef struct packed {
        logic [BUF_W-1:0]  bsel;
        logic [FILL_W-1:0] count;
        logic [WORD_W-1:0] header;
    } cmd_t;

    // Store write from the front into the packet memory.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [MEM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } wr_t;

    // Buffer release from the back once a packet has fully left.
    typedef struct packed {
        logic             en;
        logic [BUF_W-1:0] bsel;
    } rel_t;

endpackage

>>> src/kwpa_if.sv
// Valid/ready channel interfaces of the packet assembler: the event input
// and the packet result output. Depends on kwpa_pkg.
interface kwpa_in_if;
    import kwpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] event_key;
    logic [WORD_W-1:0] event_word;

    modport source (output valid, output event_key, output event_word, input ready);
    modport sink   (input valid, input event_key, input event_word, output ready);
endinterface

interface kwpa_out_if;
    import kwpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_first;
    logic [WORD_W-1:0] word_second;
    logic [NW_W-1:0]   words_valid;
    logic              packet_end;

    modport source (output valid, output word_first, output word_second,
                    output words_valid, output packet_end, input ready);
    modport sink   (input valid, input word_first, input word_second,
                    input words_valid, input packet_end, output ready);
endinterface

>>> src/kwpa_queue.sv
// Two-entry command queue between the front and the back of the assembler.
// Depends on kwpa_pkg.
module kwpa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  kwpa_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            head_valid,
    output kwpa_pkg::cmd_t  head_cmd
);
    import kwpa_pkg::*;

    cmd_t              entry_reg [NUM_BUFS];
    logic [BUF_W-1:0]  wr_ptr_reg;
    logic [BUF_W-1:0]  wr_ptr_next;
    logic [BUF_W-1:0]  rd_ptr_reg;
    logic [BUF_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + BUF_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + BUF_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/kwpa_front.sv
// Front of the assembler: configuration registers, key classification,
// header, sequence and fill tracking, store writes and flush commands.
// Depends on kwpa_pkg and kwpa_if.
module kwpa_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kwpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kwpa_pkg::WORD_W-1:0]     cfg_data,
    kwpa_in_if.sink                         event_in,
    input  kwpa_pkg::rel_t                  release_bus,
    output logic                            push,
    output kwpa_pkg::cmd_t                  push_cmd,
    output kwpa_pkg::wr_t                   store_wr
);
    import kwpa_pkg::*;

    logic [WORD_W-1:0]   new_seq_id_reg;
    logic [WORD_W-1:0]   first_data_id_reg;
    logic [WORD_W-1:0]   end_marker_id_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [WORD_W-1:0]   seq_reg;
    logic [WORD_W-1:0]   seq_next;
    logic [WORD_W-1:0]   header_reg;
    logic [WORD_W-1:0]   header_next;
    logic [BUF_W-1:0]    wr_sel_reg;
    logic [BUF_W-1:0]    wr_sel_next;
    logic [NUM_BUFS-1:0] busy_reg;
    logic [NUM_BUFS-1:0] busy_next;

    logic                accept;
    logic                is_new_seq;
    logic                is_first_data;
    logic                is_end;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   cnt;
    logic [WORD_W-1:0]   hdr;
    logic [WORD_W-1:0]   seq;
    logic [WORD_W-1:0]   seq_inc;
    logic                do_flush;

    // The buffer being filled must not still be waiting to drain.
    assign event_in.ready = !busy_reg[wr_sel_reg];
    assign accept         = event_in.valid && event_in.ready;

    assign is_new_seq    = (event_in.event_key == new_seq_id_reg);
    assign is_first_data = (event_in.event_key == first_data_id_reg);
    assign is_end        = (event_in.event_key == end_marker_id_reg);
    assign fill_inc      = fill_reg + FILL_W'(1);

    // Classification and packet bookkeeping for one accepted event, and buffer ownership.
    always_comb
    begin
        fill_next   = fill_reg;
        seq_next    = seq_reg;
        header_next = header_reg;
        wr_sel_next = wr_sel_reg;
        busy_next   = busy_reg;
        push        = 1'b0;
        push_cmd    = '{bsel: wr_sel_reg, count: fill_reg, header: header_reg};
        store_wr    = '{en: 1'b0, bank: fill_reg[0],
                        addr: {wr_sel_reg, ROW_W'(fill_reg >> 1)},
                        data: event_in.event_word};
        hdr         = header_reg;
        seq         = seq_reg;
        cnt         = fill_inc;
        do_flush    = 1'b0;
        seq_inc     = '0;

        if (accept)
        begin
            if (is_new_seq)
            begin
                // Flush unless the packet holds only its header.
                push        = (fill_reg != FILL_W'(1));
                header_next = event_in.event_word;
                seq_next    = event_in.event_word;
                fill_next   = FILL_W'(1);
            end
            else
            begin
                // Word zero lives in the header register, the rest in the store.
                if (fill_reg == '0)
                begin
                    hdr = event_in.event_word;
                end
                else
                begin
                    store_wr.en = 1'b1;
                end
                if (is_first_data)
                begin
                    seq = '0;
                    hdr = '0;
                    cnt = FILL_W'(1);
                end
                if (is_end)
                begin
                    hdr      = hdr | END_FLAG;
                    cnt      = cnt - FILL_W'(1);
                    do_flush = 1'b1;
                end
                else if (cnt >= FILL_W'(PACKET_WORDS))
                begin
                    do_flush = 1'b1;
                end

                seq_inc = seq + WORD_W'(1);
                if (do_flush)
                begin
                    push        = 1'b1;
                    push_cmd    = '{bsel: wr_sel_reg, count: cnt, header: hdr};
                    seq_next    = seq_inc;
                    header_next = seq_inc;
                    fill_next   = FILL_W'(1);
                end
                else
                begin
                    seq_next    = seq;
                    header_next = hdr;
                    fill_next   = cnt;
                end
            end
        end

        // Buffer ownership: release from the back, hand-off on a flush.
        if (release_bus.en)
        begin
            busy_next[release_bus.bsel] = 1'b0;
        end
        if (push)
        begin
            busy_next[wr_sel_reg] = 1'b1;
            wr_sel_next           = ~wr_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_seq_id_reg    <= '0;
            first_data_id_reg <= '0;
            end_marker_id_reg <= '0;
            fill_reg          <= '0;
            seq_reg           <= '0;
            header_reg        <= '0;
            wr_sel_reg        <= '0;
            busy_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NEW_SEQ:    new_seq_id_reg    <= cfg_data;
                    CFG_FIRST_DATA: first_data_id_reg <= cfg_data;
                    CFG_END_MARKER: end_marker_id_reg <= cfg_data;
                    default:        ;
                endcase
            end
            fill_reg   <= fill_next;
            seq_reg    <= seq_next;
            header_reg <= header_next;
            wr_sel_reg <= wr_sel_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

>>> src/kwpa_back.sv
// Back of the assembler: the double-buffered packet store and the drain
// sequencer that sends each flushed packet as word pairs.
// Depends on kwpa_pkg and kwpa_if.
module kwpa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  kwpa_pkg::wr_t   store_wr,
    input  logic            head_valid,
    input  kwpa_pkg::cmd_t  head_cmd,
    output logic            pop,
    output kwpa_pkg::rel_t  release_bus,
    kwpa_out_if.source      packet_out
);
    import kwpa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    // Even and odd words of each row, both buffers side by side.
    logic [WORD_W-1:0] mem_even [MEM_DEPTH];
    logic [WORD_W-1:0] mem_odd  [MEM_DEPTH];
    logic [WORD_W-1:0] even_rd_reg;
    logic [WORD_W-1:0] odd_rd_reg;
    logic [MEM_AW-1:0] rd_addr;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cur_reg;
    cmd_t              cur_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] first_next;
    logic [WORD_W-1:0] second_reg;
    logic [WORD_W-1:0] second_next;
    logic [NW_W-1:0]   nwords_reg;
    logic [NW_W-1:0]   nwords_next;
    logic              last_reg;
    logic              last_next;

    logic [FILL_W:0]   pos;
    logic [FILL_W:0]   count_ext;
    logic              pair;
    logic              tail;

    assign rd_addr = {cur_reg.bsel, row_reg};

    // Store: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            if (store_wr.bank)
            begin
                mem_odd[store_wr.addr] <= store_wr.data;
            end
            else
            begin
                mem_even[store_wr.addr] <= store_wr.data;
            end
        end
        even_rd_reg <= mem_even[rd_addr];
        odd_rd_reg  <= mem_odd[rd_addr];
    end

    // Position of the first word of the current row within the packet.
    assign pos       = (FILL_W + 1)'({row_reg, 1'b0});
    assign count_ext = (FILL_W + 1)'(cur_reg.count);
    assign pair      = (pos + (FILL_W + 1)'(1)) < count_ext;
    assign tail      = (pos + (FILL_W + 1)'(2)) >= count_ext;

    // Drain sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        nwords_next    = nwords_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        release_bus    = '{en: 1'b0, bsel: cur_reg.bsel};

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    cur_next   = head_cmd;
                    row_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (cur_reg.count == '0)
                begin
                    // An empty packet is one result with no words.
                    first_next     = '0;
                    second_next    = '0;
                    nwords_next    = NW_NONE;
                    last_next      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_SEND;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                first_next     = (row_reg == '0) ? cur_reg.header : even_rd_reg;
                second_next    = pair ? odd_rd_reg : '0;
                nwords_next    = pair ? NW_TWO : NW_ONE;
                last_next      = tail;
                out_valid_next = 1'b1;
                state_next     = ST_SEND;
            end
            ST_SEND:
            begin
                if (packet_out.ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        release_bus.en = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        nwords_reg <= nwords_next;
        last_reg   <= last_next;
    end

    assign packet_out.valid       = out_valid_reg;
    assign packet_out.word_first  = first_reg;
    assign packet_out.word_second = second_reg;
    assign packet_out.words_valid = nwords_reg;
    assign packet_out.packet_end  = last_reg;

endmodule

>>> src/keyed_word_packet_assembler.sv
// Keyed word packet assembler, top level. Depends on kwpa_pkg, kwpa_if,
// kwpa_queue, kwpa_front, kwpa_back and assert_macros.svh.
//
// Events are accepted one per cycle while the packet buffer being filled is
// free; the front keeps two packet buffers and swaps on every flush. The
// drain sequencer sends each flushed packet as word pairs, every pair going
// through fetch, registered memory read and the output register, and an
// empty packet as one result with no words; a stalled output holds either.
// The front stalls only when both buffers are waiting to drain. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module keyed_word_packet_assembler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kwpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kwpa_pkg::WORD_W-1:0]     cfg_data,
    kwpa_in_if.sink                         event_in,
    kwpa_out_if.source                      packet_out
);
    import kwpa_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;
    wr_t  store_wr;
    rel_t release_bus;

    // Accept and classify events, track the open packet.
    kwpa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .event_in    (event_in),
        .release_bus (release_bus),
        .push        (push),
        .push_cmd    (push_cmd),
        .store_wr    (store_wr)
    );

    // Flush commands waiting for the back.
    kwpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Packet store and drain into word pairs.
    kwpa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_wr    (store_wr),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .release_bus (release_bus),
        .packet_out  (packet_out)
    );

    // A result without words is always the whole packet.
    `KWPA_ASSERT_IMPLIES(a_empty_is_end, packet_out.valid && (packet_out.words_valid == NW_NONE), packet_out.packet_end, "empty result without packet end")
    // A buffer is released only as the last result of its packet is taken.
    `KWPA_ASSERT_IMPLIES(a_release_on_end, release_bus.en, packet_out.valid && packet_out.ready && packet_out.packet_end, "buffer released without final transaction")
    // After a release the back returns to idle with no result showing.
    `KWPA_ASSERT_NEXT(a_idle_after_release, release_bus.en, !packet_out.valid, "result shown right after release")
    // A flush never hands off the buffer being released in the same cycle.
    `KWPA_ASSERT_IMPLIES(a_push_other_buf, push && release_bus.en, push_cmd.bsel != release_bus.bsel, "flush into a buffer still draining")

endmodule
